// File: hw/rtl/pfe_pkg.sv
`default_nettype none

package pfe_pkg;

  // Stack geometry and arithmetic width
  localparam int STACK_DEPTH = 16;
  localparam int VALUE_W     = 16;
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(VALUE_W);

  // Queue between front and back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Stream payload widths
  localparam int SYMBOL_W    = 8;
  localparam int OUT_VALUE_W = 16;
  localparam int STATUS_W    = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  // Character codes
  localparam logic [SYMBOL_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYMBOL_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYMBOL_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [SYMBOL_W-1:0] CH_NINE  = 8'h39;

  typedef logic [VALUE_W-1:0] val_t;

  // Symbol class produced by the front end
  typedef enum logic [2:0] {
    K_DIGIT = 3'd0,
    K_ADD   = 3'd1,
    K_SUB   = 3'd2,
    K_MUL   = 3'd3,
    K_DIV   = 3'd4,
    K_BAD   = 3'd5
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADCHAR  = 3'd1,
    ST_UNDER    = 3'd2,
    ST_OVER     = 3'd3,
    ST_DIVZERO  = 3'd4,
    ST_LEFTOVER = 3'd5
  } status_t;

  // Classified symbol held in the queue
  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       last;
  } item_t;

  // Request to the divide unit
  typedef struct packed {
    logic start;
    val_t dividend;
    val_t divisor;
  } div_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/pfe_front.sv
`default_nettype none

module pfe_front
  import pfe_pkg::*;
(
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // [7:0] symbol
  input  wire logic                  in_tlast,   // last
  input  wire logic                  q_full,
  output logic                       q_push,
  output item_t                      q_item
);

  logic [SYMBOL_W-1:0] sym;

  assign sym       = in_tdata[SYMBOL_W-1:0];
  assign in_tready = rst_n && !q_full;
  assign q_push    = in_tvalid && in_tready;

  // Classify the character into a digit, an operator or a bad symbol
  always_comb begin
    q_item.last  = in_tlast;
    q_item.digit = 4'(sym - CH_ZERO);
    if (sym inside {[CH_ZERO:CH_NINE]}) begin
      q_item.kind = K_DIGIT;
    end else begin
      case (sym)
        CH_PLUS:  q_item.kind = K_ADD;
        CH_MINUS: q_item.kind = K_SUB;
        CH_STAR:  q_item.kind = K_MUL;
        CH_SLASH: q_item.kind = K_DIV;
        default:  q_item.kind = K_BAD;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfe_queue.sv
`default_nettype none

module pfe_queue
  import pfe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      head,
  output logic       empty
);

  item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full    = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store the incoming item
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pfe_div.sv
`default_nettype none

module pfe_div
  import pfe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output logic          done,
  output val_t          quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [VALUE_W:0]     rem_r, rem_nxt;
  val_t                 quo_r, quo_nxt;
  val_t                 dvs_r;
  logic                 neg_r;
  logic                 neg_a, neg_b;
  val_t                 mag_a, mag_b;
  logic [VALUE_W:0]     shifted, diff;

  // Operand magnitudes and result sign
  assign neg_a = req.dividend[VALUE_W-1];
  assign neg_b = req.divisor[VALUE_W-1];
  assign mag_a = neg_a ? val_t'('0) - req.dividend : req.dividend;
  assign mag_b = neg_b ? val_t'('0) - req.divisor  : req.divisor;

  // One restoring step per cycle
  always_comb begin
    shifted = {rem_r[VALUE_W-1:0], quo_r[VALUE_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    if (!diff[VALUE_W]) begin
      rem_nxt = diff;
      quo_nxt = {quo_r[VALUE_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted;
      quo_nxt = {quo_r[VALUE_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && cnt_r == DIV_CNT_W'(VALUE_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= neg_a ^ neg_b;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? val_t'('0) - quo_r : quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/pfe_back.sv
`default_nettype none

module pfe_back
  import pfe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire item_t                  head,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output div_req_t                    div_req,
  input  wire logic                   div_done,
  input  wire val_t                   div_q,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // [15:0] value, [18:16] status
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt, after_op;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  status_t                err_r, err_nxt;
  kind_t                  kind_r, kind_nxt;
  logic                   last_r, last_nxt;

  val_t                   stack_mem [STACK_DEPTH];
  val_t                   rd_a_r, rd_b_r;
  logic [IDX_W-1:0]       rd_a_addr, rd_b_addr;
  logic                   we;
  logic [IDX_W-1:0]       waddr;
  val_t                   wdata;
  val_t                   alu_res;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  status_t                out_status_r, out_status_nxt;
  status_t                fin_status;

  // Read the top two entries, or the bottom one while finishing
  always_comb begin
    rd_a_addr = IDX_W'(cnt_r - CNT_W'(2));
    if (state_r == S_FIN || state_r == S_EMIT) begin
      rd_b_addr = '0;
    end else begin
      rd_b_addr = IDX_W'(cnt_r - CNT_W'(1));
    end
  end

  // Stack memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[waddr] <= wdata;
    end
    rd_a_r <= stack_mem[rd_a_addr];
    rd_b_r <= stack_mem[rd_b_addr];
  end

  // Add, subtract or multiply, wrapping at the value width
  always_comb begin
    case (kind_r)
      K_ADD:   alu_res = rd_a_r + rd_b_r;
      K_SUB:   alu_res = rd_a_r - rd_b_r;
      K_MUL:   alu_res = rd_a_r * rd_b_r;
      default: alu_res = rd_a_r;
    endcase
  end

  assign after_op = last_r ? S_FIN : S_IDLE;

  always_comb begin
    if (err_r != ST_OK) begin
      fin_status = err_r;
    end else if (cnt_r == CNT_W'(1)) begin
      fin_status = ST_OK;
    end else begin
      fin_status = ST_LEFTOVER;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    err_nxt          = err_r;
    kind_nxt         = kind_r;
    last_nxt         = last_r;
    q_pop            = 1'b0;
    we               = 1'b0;
    waddr            = IDX_W'(cnt_r - CNT_W'(2));
    wdata            = alu_res;
    div_req.start    = 1'b0;
    div_req.dividend = rd_a_r;
    div_req.divisor  = rd_b_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_value_nxt    = out_value_r;
    out_status_nxt   = out_status_r;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          kind_nxt  = head.kind;
          last_nxt  = head.last;
          state_nxt = head.last ? S_FIN : S_IDLE;
          if (err_r == ST_OK) begin
            case (head.kind)
              K_DIGIT: begin
                if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
                  err_nxt = ST_OVER;
                end else begin
                  we      = 1'b1;
                  waddr   = cnt_r[IDX_W-1:0];
                  wdata   = VALUE_W'(head.digit);
                  cnt_nxt = cnt_r + 1'b1;
                end
              end
              K_BAD: err_nxt = ST_BADCHAR;
              default: begin
                if (cnt_r < CNT_W'(2)) begin
                  err_nxt = ST_UNDER;
                end else begin
                  state_nxt = S_EXEC;
                end
              end
            endcase
          end
        end
      end
      S_EXEC: begin
        if (kind_r == K_DIV) begin
          if (rd_b_r == '0) begin
            err_nxt   = ST_DIVZERO;
            cnt_nxt   = cnt_r - CNT_W'(2);
            state_nxt = after_op;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = S_DIV;
          end
        end else begin
          we        = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = after_op;
        end
      end
      S_DIV: begin
        if (div_done) begin
          we        = 1'b1;
          wdata     = div_q;
          cnt_nxt   = cnt_r - CNT_W'(1);
          state_nxt = after_op;
        end
      end
      S_FIN: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_value_nxt  = (fin_status == ST_OK) ? OUT_VALUE_W'(rd_b_r) : '0;
          cnt_nxt        = '0;
          err_nxt        = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    last_r       <= last_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_status_r, out_value_r});

endmodule

`default_nettype wire

// File: hw/rtl/postfix_expression_evaluator.sv
`default_nettype none

// Channel  Dir  Ports                              Payload
// in       in   in_tvalid in_tready in_tdata      tdata[7:0] symbol; tlast = last
//                in_tlast
// out      out  out_tvalid out_tready out_tdata   tdata[15:0] value, [18:16] status
//
// A digit or a bad character is handled on its own pop; add, subtract and multiply
// read the stack, then write back; a divide starts the one-bit-per-cycle restoring
// divider and waits for its quotient. The final character then reads the bottom
// entry and loads the result register, waiting while it still holds a result.
// A 4-entry queue decouples input from evaluation; in_tready is low while it is
// full or in reset. Synchronous active-low reset empties the stack and the queue.

module postfix_expression_evaluator
  import pfe_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] symbol
  input  wire logic                   in_tlast,   // last
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // [15:0] value, [18:16] status
);

  logic     q_push, q_full, q_pop, q_empty;
  item_t    q_in, q_head;
  div_req_t div_req;
  logic     div_done;
  val_t     div_q;

  pfe_front u_front (
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in)
  );

  pfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  pfe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  pfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_done   (div_done),
    .div_q      (div_q),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// File: tb/postfix_expression_evaluator_tb.sv
`timescale 1ns / 1ps

module postfix_expression_evaluator_tb
  import pfe_pkg::*;
;

  localparam int RAND_ITEMS     = 1900;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 60;
  localparam int NUM_DIR_ROWS   = 26;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    status_t                status;
  } result_t;

  // One row of the directed table; typed rows carry their own expected result
  typedef struct packed {
    logic [SYMBOL_W-1:0]    sym;
    logic                   lst;
    logic                   typed;
    logic [OUT_VALUE_W-1:0] value;
    status_t                status;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [7:0] symbol
  logic                   in_tlast;   // last
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] value, [18:16] status

  postfix_expression_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the evaluator state
  val_t        calc_stack [STACK_DEPTH];
  int unsigned calc_depth;
  status_t     calc_error;

  result_t         pending_results [$];
  logic [SYMBOL_W-1:0] expr_syms [$];

  int mismatches    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int status_seen [8];
  int tx_max_gap    = 10;
  int rx_hold_req   = 0;
  int rx_hold_done  = 0;

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{"5",      1'b1, 1'b1, 16'd0 + 16'd5, ST_OK},
    '{8'hFF,    1'b1, 1'b1, 16'd0, ST_BADCHAR},
    '{CH_PLUS,  1'b1, 1'b1, 16'd0, ST_UNDER},
    '{"3",      1'b0, 1'b0, 16'd0, ST_OK},
    '{"0",      1'b0, 1'b0, 16'd0, ST_OK},
    '{CH_SLASH, 1'b1, 1'b1, 16'd0, ST_DIVZERO},
    '{"1",      1'b0, 1'b0, 16'd0, ST_OK},
    '{"2",      1'b1, 1'b1, 16'd0, ST_LEFTOVER},
    '{"3",      1'b0, 1'b0, 16'd0, ST_OK},
    '{"7",      1'b0, 1'b0, 16'd0, ST_OK},
    '{CH_MINUS, 1'b1, 1'b0, 16'd0, ST_OK},
    '{"0",      1'b0, 1'b0, 16'd0, ST_OK},
    '{"7",      1'b0, 1'b0, 16'd0, ST_OK},
    '{CH_MINUS, 1'b0, 1'b0, 16'd0, ST_OK},
    '{"2",      1'b0, 1'b0, 16'd0, ST_OK},
    '{CH_SLASH, 1'b1, 1'b0, 16'd0, ST_OK},
    '{"9",      1'b0, 1'b0, 16'd0, ST_OK},
    '{"9",      1'b0, 1'b0, 16'd0, ST_OK},
    '{CH_STAR,  1'b0, 1'b0, 16'd0, ST_OK},
    '{CH_PLUS,  1'b0, 1'b0, 16'd0, ST_OK},
    '{8'hFF,    1'b0, 1'b0, 16'd0, ST_OK},
    '{"4",      1'b1, 1'b1, 16'd0, ST_UNDER},
    '{8'h00,    1'b1, 1'b1, 16'd0, ST_BADCHAR},
    '{"4",      1'b0, 1'b0, 16'd0, ST_OK},
    '{"8",      1'b0, 1'b0, 16'd0, ST_OK},
    '{CH_PLUS,  1'b1, 1'b0, 16'd0, ST_OK}
  };

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advance the shadow state by one symbol; produce a result on the final one
  task automatic eval_symbol(input logic [SYMBOL_W-1:0] sym, input logic lst,
                             output bit produced, output result_t res);
    val_t a, b, ma, mb, q, r;
    bit   push_r;
    produced   = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (calc_error == ST_OK) begin
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
        if (calc_depth >= STACK_DEPTH) begin
          calc_error = ST_OVER;
        end else begin
          calc_stack[calc_depth] = val_t'(sym - CH_ZERO);
          calc_depth++;
        end
      end else if (sym != CH_PLUS && sym != CH_MINUS && sym != CH_STAR &&
                   sym != CH_SLASH) begin
        calc_error = ST_BADCHAR;
      end else if (calc_depth < 2) begin
        calc_error = ST_UNDER;
      end else begin
        b = calc_stack[calc_depth-1];
        a = calc_stack[calc_depth-2];
        calc_depth -= 2;
        push_r = 1'b1;
        r = '0;
        case (sym)
          CH_PLUS:  r = a + b;
          CH_MINUS: r = a - b;
          CH_STAR:  r = a * b;
          default: begin
            // Truncate toward zero on magnitudes, then restore the sign
            if (b == '0) begin
              calc_error = ST_DIVZERO;
              push_r = 1'b0;
            end else begin
              ma = a[VALUE_W-1] ? -a : a;
              mb = b[VALUE_W-1] ? -b : b;
              q  = ma / mb;
              r  = (a[VALUE_W-1] ^ b[VALUE_W-1]) ? -q : q;
            end
          end
        endcase
        if (push_r) begin
          calc_stack[calc_depth] = r;
          calc_depth++;
        end
      end
    end
    if (lst) begin
      produced = 1'b1;
      if (calc_error != ST_OK) res.status = calc_error;
      else if (calc_depth == 1) res.value = calc_stack[0][OUT_VALUE_W-1:0];
      else res.status = ST_LEFTOVER;
      calc_depth = 0;
      calc_error = ST_OK;
    end
  endtask

  // Offer one symbol after a random gap; predict once the transaction completes
  task automatic push_symbol(input logic [SYMBOL_W-1:0] sym, input logic lst,
                             input bit typed, input result_t typed_res);
    int      gap;
    bit      produced;
    result_t res;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    eval_symbol(sym, lst, produced, res);
    if (produced) pending_results.push_back(typed ? typed_res : res);
  endtask

  // Hold the input idle until every predicted result has been taken
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Fill expr_syms with one expression: mostly well formed, some broken or noise
  task automatic build_expression();
    int pick, n_opnd, depth, pushed;
    logic [SYMBOL_W-1:0] op_set [4];
    op_set = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    expr_syms.delete();
    pick = $urandom_range(0, 99);
    if (pick >= 94) begin
      // 8^5 wraps to the most negative value, then divide it by -1
      expr_syms = '{"8", "8", CH_STAR, "8", CH_STAR, "8", CH_STAR, "8", CH_STAR,
                    "0", "1", CH_MINUS, CH_SLASH};
    end else if (pick >= 86) begin
      // Run the stack up to and past its depth
      repeat ($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2))
        expr_syms.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1)) expr_syms.push_back(op_set[$urandom_range(0, 3)]);
    end else if (pick >= 78) begin
      repeat ($urandom_range(1, 6)) expr_syms.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_opnd = ($urandom_range(0, 7) == 0) ? $urandom_range(9, STACK_DEPTH)
                                           : $urandom_range(1, 8);
      depth  = 0;
      pushed = 0;
      while (pushed < n_opnd || depth > 1) begin
        if (pushed < n_opnd && (depth < 2 || $urandom_range(0, 1))) begin
          expr_syms.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
          depth++;
          pushed++;
        end else begin
          expr_syms.push_back(op_set[$urandom_range(0, 3)]);
          depth--;
        end
      end
      // Break a share of the well-formed ones
      if (pick >= 70) begin
        case ($urandom_range(0, 2))
          0: expr_syms[$urandom_range(0, expr_syms.size() - 1)] = 8'($urandom_range(0, 255));
          1: if (expr_syms.size() > 1)
               expr_syms.delete($urandom_range(0, expr_syms.size() - 1));
          default: expr_syms.insert($urandom_range(0, expr_syms.size() - 1),
                                    op_set[$urandom_range(0, 3)]);
        endcase
      end
    end
  endtask

  // Stimulus: reset, directed table, then random expressions
  initial begin : stimulus
    result_t typed_res;
    int      rand_items;
    int      burst_exprs;
    bit      hold_issued;
    bit      mid_drained;
    rand_items  = 0;
    burst_exprs = 0;
    hold_issued = 1'b0;
    mid_drained = 1'b0;
    calc_depth  = 0;
    calc_error  = ST_OK;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      typed_res.value  = dir_rows[i].value;
      typed_res.status = dir_rows[i].status;
      push_symbol(dir_rows[i].sym, dir_rows[i].lst, dir_rows[i].typed, typed_res);
    end
    drain_results();

    typed_res.value  = '0;
    typed_res.status = ST_OK;
    while (rand_items < RAND_ITEMS) begin
      // Long receiver hold with the sender at full rate
      if (!hold_issued && rand_items >= RAND_ITEMS / 3) begin
        rx_hold_req++;
        burst_exprs = 15;
        hold_issued = 1'b1;
      end
      if (!mid_drained && rand_items >= (2 * RAND_ITEMS) / 3) begin
        drain_results();
        mid_drained = 1'b1;
      end
      if (burst_exprs > 0) begin
        tx_max_gap = 0;
        burst_exprs--;
      end else begin
        tx_max_gap = ($urandom_range(0, 5) == 0) ? 0 : 10;
      end
      build_expression();
      foreach (expr_syms[i])
        push_symbol(expr_syms[i], i == expr_syms.size() - 1, 1'b0, typed_res);
      rand_items += expr_syms.size();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d symbols and %0d results: ok %0d, bad char %0d, underflow %0d,",
             items_sent, results_seen, status_seen[ST_OK], status_seen[ST_BADCHAR],
             status_seen[ST_UNDER]);
    $display("  overflow %0d, divide by zero %0d, leftover %0d, %0d long output holds",
             status_seen[ST_OVER], status_seen[ST_DIVZERO], status_seen[ST_LEFTOVER],
             rx_hold_done);
    if (mismatches == 0) begin
      $display("postfix_expression_evaluator_tb OK");
    end else begin
      $display("postfix_expression_evaluator_tb NOT OK");
    end
    $finish;
  end

  // Result side: random back-pressure, occasional long hold, check each transaction
  initial begin : result_sink
    int                     gap;
    int                     quiet_left;
    result_t                want;
    logic [OUT_VALUE_W-1:0] got_value;
    logic [STATUS_W-1:0]    got_status;
    quiet_left = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (quiet_left > 0) begin
        gap = 0;
        quiet_left--;
      end else begin
        if ($urandom_range(0, 9) == 0) quiet_left = 20;
        gap = $urandom_range(0, 10);
      end
      if (rx_hold_done < rx_hold_req) begin
        gap += RX_HOLD_CYCLES;
        rx_hold_done++;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got_value  = out_tdata[OUT_VALUE_W-1:0];
      got_status = out_tdata[OUT_VALUE_W +: STATUS_W];
      results_seen++;
      status_seen[got_status]++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value %0d status %0d",
                                $signed(got_value), got_status));
      end else begin
        want = pending_results.pop_front();
        if (got_status != want.status)
          flag_mismatch($sformatf("result %0d status %0d, expected %0d",
                                  results_seen, got_status, want.status));
        if (got_value != want.value)
          flag_mismatch($sformatf("result %0d value %0d, expected %0d", results_seen,
                                  $signed(got_value), $signed(want.value)));
      end
    end
  end

  // Guard against a hung handshake
  initial begin : watchdog
    #4_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("postfix_expression_evaluator_tb NOT OK");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_front.sv
hw/rtl/pfe_queue.sv
hw/rtl/pfe_div.sv
hw/rtl/pfe_back.sv
hw/rtl/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_tb.sv
